FILE: hdl/rc4_pkg.sv
// rc4_pkg: shared types and constants of the RC4 stream cipher engine.
// Used by rc4_perm_ram and rc4_stream_cipher; depends on nothing.
package rc4_pkg;

  localparam int PermSize = 256;
  localparam int AddrW    = $clog2(PermSize);
  localparam int ByteW    = 8;
  localparam int MaxKey   = 32;
  localparam int KeyIdxW  = 5;
  localparam int KeyLenW  = 6;
  localparam int TdataW   = 16;

  localparam logic [KeyLenW-1:0] KeyLenReset = KeyLenW'(20);
  localparam logic [AddrW-1:0]   LastEntry   = AddrW'(PermSize - 1);

  typedef enum logic [1:0] {
    MODE_KEY   = 2'd0,
    MODE_SCHED = 2'd1,
    MODE_CRYPT = 2'd2
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_KS_A,
    ST_KS_B,
    ST_KS_C,
    ST_CR_I,
    ST_CR_J,
    ST_CR_W,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    logic [ByteW-1:0] data;
  } perm_wr_t;

endpackage

FILE: hdl/rc4_perm_ram.sv
// rc4_perm_ram: 256 x 8 permutation memory, one write port, two registered read ports.
// A read of the entry written in the same cycle returns the new data.
// Depends on rc4_pkg.
module rc4_perm_ram import rc4_pkg::*; (
  input  logic             clk,
  input  perm_wr_t         wr,
  input  logic [AddrW-1:0] raddr_a,
  input  logic [AddrW-1:0] raddr_b,
  output logic [ByteW-1:0] rdata_a,
  output logic [ByteW-1:0] rdata_b
);

  logic [ByteW-1:0] mem [PermSize];
  logic [ByteW-1:0] q_a;
  logic [ByteW-1:0] q_b;
  logic [ByteW-1:0] wdata_r;
  logic             hit_a;
  logic             hit_b;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    q_a     <= mem[raddr_a];
    q_b     <= mem[raddr_b];
    wdata_r <= wr.data;
    hit_a   <= wr.en && (wr.addr == raddr_a);
    hit_b   <= wr.en && (wr.addr == raddr_b);
  end

  assign rdata_a = hit_a ? wdata_r : q_a;
  assign rdata_b = hit_b ? wdata_r : q_b;

endmodule

FILE: hdl/rc4_stream_cipher.sv
// rc4_stream_cipher: RC4 engine with key store, key schedule and crypt step.
// Depends on rc4_pkg and rc4_perm_ram.
// Crypt: each input byte steps through ST_CR_I, ST_CR_J and ST_CR_W on the single
//   permutation memory; the next byte is taken in ST_CR_W, or in ST_IDLE after ST_HOLD.
// Key schedule: fill of all 256 entries, then ST_KS_A, ST_KS_B, ST_KS_C per swap step.
// Reset (rst, synchronous): pointers zero, key_length 20, output empty; permutation
//   and key store hold nothing until written.
module rc4_stream_cipher import rc4_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [KeyLenW-1:0] cfg_wr_data,     // key_length
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [TdataW-1:0]  s_axis_tdata,    // [4:0] key_index, [12:5] byte_value
  input  logic [1:0]         s_axis_tuser,    // [1:0] mode
  input  logic               s_axis_tlast,    // last
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [ByteW-1:0]   m_axis_tdata,    // [7:0] byte_out
  output logic               m_axis_tlast     // last_out
);

  state_t state;
  state_t state_next;

  logic [KeyLenW-1:0]  key_length;
  logic [ByteW-1:0]    key_store [MaxKey];
  logic [ByteW-1:0]    key_q;
  logic [AddrW-1:0]    ptr_i;
  logic [AddrW-1:0]    ptr_j;
  logic [AddrW-1:0]    cnt;
  logic [AddrW-1:0]    acc;
  logic [KeyIdxW-1:0]  kidx;
  logic [KeyIdxW-1:0]  kidx_wrap;
  logic [KeyIdxW-1:0]  kidx_next;
  logic [KeyLenW-1:0]  key_len_eff;
  logic [ByteW-1:0]    si;
  logic                t_is_j;
  logic [ByteW-1:0]    data_r;
  logic                last_r;
  logic [ByteW-1:0]    pend_byte;
  logic                pend_last;

  perm_wr_t            wr;
  logic [AddrW-1:0]    raddr_a;
  logic [AddrW-1:0]    raddr_b;
  logic [ByteW-1:0]    rd_a;
  logic [ByteW-1:0]    rd_b;

  logic                accept;
  logic                out_free;
  mode_t               mode_in;
  logic [KeyIdxW-1:0]  in_key_index;
  logic [ByteW-1:0]    in_byte;
  logic [AddrW-1:0]    i_inc;
  logic [AddrW-1:0]    j_sum;
  logic [AddrW-1:0]    acc_sum;
  logic [AddrW-1:0]    t_sum;
  logic [ByteW-1:0]    ks;
  logic [ByteW-1:0]    res;
  state_t              start_state;

  rc4_perm_ram u_perm (
    .clk     (clk),
    .wr      (wr),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  assign mode_in      = mode_t'(s_axis_tuser);
  assign in_key_index = s_axis_tdata[KeyIdxW-1:0];
  assign in_byte      = s_axis_tdata[KeyIdxW +: ByteW];
  assign accept       = s_axis_tvalid && s_axis_tready;
  assign out_free     = !m_axis_tvalid || m_axis_tready;

  assign i_inc   = ptr_i + AddrW'(1);
  assign j_sum   = ptr_j + rd_a;
  assign acc_sum = acc + key_q + rd_a;
  assign t_sum   = si + rd_a;
  assign ks      = t_is_j ? si : rd_b;
  assign res     = data_r ^ ks;

  always_comb begin
    if (key_length == '0) begin
      key_len_eff = KeyLenW'(1);
    end else if (key_length > KeyLenW'(MaxKey)) begin
      key_len_eff = KeyLenW'(MaxKey);
    end else begin
      key_len_eff = key_length;
    end
  end

  always_comb begin
    if ((KeyLenW'(kidx) + KeyLenW'(1)) >= key_len_eff) begin
      kidx_wrap = '0;
    end else begin
      kidx_wrap = kidx + KeyIdxW'(1);
    end
  end

  always_comb begin
    if (accept && (mode_in == MODE_SCHED)) begin
      kidx_next = '0;
    end else if (state == ST_KS_C) begin
      kidx_next = kidx_wrap;
    end else begin
      kidx_next = kidx;
    end
  end

  always_comb begin
    unique case (mode_in)
      MODE_CRYPT: start_state = ST_CR_I;
      MODE_SCHED: start_state = ST_FILL;
      default:    start_state = ST_IDLE;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = start_state;
      end
      ST_FILL: begin
        if (cnt == LastEntry) state_next = ST_KS_A;
      end
      ST_KS_A: state_next = ST_KS_B;
      ST_KS_B: state_next = ST_KS_C;
      ST_KS_C: begin
        state_next = (cnt == LastEntry) ? ST_IDLE : ST_KS_A;
      end
      ST_CR_I: state_next = ST_CR_J;
      ST_CR_J: state_next = ST_CR_W;
      ST_CR_W: begin
        if (accept) begin
          state_next = start_state;
        end else begin
          state_next = out_free ? ST_IDLE : ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // memory control and handshake
  always_comb begin
    s_axis_tready = 1'b0;
    wr            = '0;
    raddr_a       = i_inc;
    raddr_b       = t_sum;
    unique case (state)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_FILL: begin
        wr      = '{en: 1'b1, addr: cnt, data: ByteW'(cnt)};
        raddr_a = cnt + AddrW'(1);
      end
      ST_KS_A: raddr_a = acc_sum;
      ST_KS_B: wr = '{en: 1'b1, addr: cnt, data: rd_a};
      ST_KS_C: begin
        wr      = '{en: 1'b1, addr: acc, data: si};
        raddr_a = cnt + AddrW'(1);
      end
      ST_CR_I: raddr_a = j_sum;
      ST_CR_J: wr = '{en: 1'b1, addr: ptr_i, data: rd_a};
      ST_CR_W: begin
        s_axis_tready = out_free;
        wr            = '{en: 1'b1, addr: ptr_j, data: si};
      end
      ST_HOLD: s_axis_tready = 1'b0;
      default: s_axis_tready = 1'b0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      ptr_i         <= '0;
      ptr_j         <= '0;
      key_length    <= KeyLenReset;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        key_length <= cfg_wr_data;
      end
      if (accept && (mode_in == MODE_SCHED)) begin
        ptr_i <= '0;
        ptr_j <= '0;
      end else if (accept && (mode_in == MODE_CRYPT)) begin
        ptr_i <= i_inc;
      end else if (state == ST_CR_I) begin
        ptr_j <= j_sum;
      end
      if (((state == ST_CR_W) || (state == ST_HOLD)) && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept && (mode_in == MODE_KEY) && (KeyLenW'(in_key_index) < KeyLenW'(MaxKey))) begin
      key_store[in_key_index] <= in_byte;
    end
    key_q <= key_store[kidx_next];
    kidx  <= kidx_next;

    if (accept && (mode_in == MODE_SCHED)) begin
      cnt <= '0;
      acc <= '0;
    end else if ((state == ST_FILL) || (state == ST_KS_C)) begin
      cnt <= cnt + AddrW'(1);
    end else if (state == ST_KS_A) begin
      acc <= acc_sum;
    end

    if (accept && (mode_in == MODE_CRYPT)) begin
      data_r <= in_byte;
      last_r <= s_axis_tlast;
    end

    if ((state == ST_KS_A) || (state == ST_CR_I)) begin
      si <= rd_a;
    end
    if (state == ST_CR_J) begin
      t_is_j <= (t_sum == ptr_j);
    end

    if (state == ST_CR_W) begin
      if (out_free) begin
        m_axis_tdata <= res;
        m_axis_tlast <= last_r;
      end else begin
        pend_byte <= res;
        pend_last <= last_r;
      end
    end else if ((state == ST_HOLD) && out_free) begin
      m_axis_tdata <= pend_byte;
      m_axis_tlast <= pend_last;
    end
  end

endmodule
